// ===== design/sm83alu_pkg.sv =====
// shared types and constants for the sm83 alu with flags
`default_nettype none

package sm83alu_pkg;

  // operation codes, codes 26 to 31 are unused and pass operand a through
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_OR    = 5'd5,
    OP_XOR   = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_SWAP  = 5'd10,
    OP_BIT   = 5'd11,
    OP_RES   = 5'd12,
    OP_SET   = 5'd13,
    OP_RLC   = 5'd14,
    OP_RRC   = 5'd15,
    OP_RL    = 5'd16,
    OP_RR    = 5'd17,
    OP_SLA   = 5'd18,
    OP_SRA   = 5'd19,
    OP_SRL   = 5'd20,
    OP_DAA   = 5'd21,
    OP_ADD16 = 5'd22,
    OP_INC16 = 5'd23,
    OP_DEC16 = 5'd24,
    OP_SPOFS = 5'd25
  } alu_op_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } alu_flags_t;

  typedef struct packed {
    alu_op_t    op;
    logic [15:0] a;
    logic [15:0] b;
    logic [2:0]  bit_index;
    alu_flags_t  flags;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] result;
    alu_flags_t  flags;
  } alu_res_t;

  // decimal adjust constants
  localparam logic [3:0] DAA_DIGIT_MAX = 4'd9;
  localparam logic [8:0] DAA_HI_LIMIT  = 9'h09F;
  localparam logic [7:0] DAA_LO_ADJ    = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ    = 8'h60;

endpackage

`default_nettype wire

// ===== design/sm83alu_core.sv =====
// combinational datapath of the sm83 alu: one request in, result and flags out
`default_nettype none

module sm83alu_core (
  input  sm83alu_pkg::alu_req_t req,
  output sm83alu_pkg::alu_res_t res
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic        ci;
  logic [8:0]  sum9;
  logic [4:0]  hsum;
  logic [8:0]  dif9;
  logic [4:0]  hdif;
  logic [7:0]  bmask;
  logic        daa_lo;
  logic [8:0]  daa_t1;
  logic        daa_hi;
  logic [8:0]  daa_t2;
  logic [7:0]  daa_sub;
  logic [7:0]  daa_r;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] sp_sum;
  logic [7:0]  r8;

  assign a8 = req.a[7:0];
  assign b8 = req.b[7:0];

  // carry folds in for adc and sbc only
  assign ci = ((req.op == sm83alu_pkg::OP_ADC) || (req.op == sm83alu_pkg::OP_SBC))
              & req.flags.c;

  // shared by add/adc and the low byte of sp plus offset
  assign sum9 = {1'b0, a8} + {1'b0, b8} + {8'h00, ci};
  assign hsum = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, ci};
  // borrows out of bit 8 and bit 4
  assign dif9 = {1'b0, a8} - {1'b0, b8} - {8'h00, ci};
  assign hdif = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'h0, ci};

  assign bmask = 8'h01 << req.bit_index;

  // decimal adjust
  assign daa_lo  = req.flags.h || (a8[3:0] > sm83alu_pkg::DAA_DIGIT_MAX);
  assign daa_t1  = {1'b0, a8} + (daa_lo ? {1'b0, sm83alu_pkg::DAA_LO_ADJ} : 9'h000);
  assign daa_hi  = req.flags.c || (daa_t1 > sm83alu_pkg::DAA_HI_LIMIT);
  assign daa_t2  = daa_t1 + (daa_hi ? {1'b0, sm83alu_pkg::DAA_HI_ADJ} : 9'h000);
  assign daa_sub = a8 - (req.flags.h ? sm83alu_pkg::DAA_LO_ADJ : 8'h00)
                      - (req.flags.c ? sm83alu_pkg::DAA_HI_ADJ : 8'h00);
  assign daa_r   = req.flags.n ? daa_sub : daa_t2[7:0];

  assign sum17  = {1'b0, req.a} + {1'b0, req.b};
  assign sum13  = {1'b0, req.a[11:0]} + {1'b0, req.b[11:0]};
  assign sp_sum = req.a + {{8{b8[7]}}, b8};

  always_comb begin
    r8        = 8'h00;
    res.result = req.a;
    res.flags  = req.flags;
    case (req.op)
      sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC: begin
        r8 = sum9[7:0];
        res.result = {8'h00, r8};
        res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: hsum[4], c: sum9[8]};
      end
      sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC, sm83alu_pkg::OP_CP: begin
        r8 = dif9[7:0];
        // compare keeps operand a
        if (req.op != sm83alu_pkg::OP_CP) begin
          res.result = {8'h00, r8};
        end
        res.flags = '{z: (r8 == 8'h00), n: 1'b1, h: hdif[4], c: dif9[8]};
      end
      sm83alu_pkg::OP_AND: begin
        r8 = a8 & b8;
        res.result = {8'h00, r8};
        res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      sm83alu_pkg::OP_OR: begin
        r8 = a8 | b8;
        res.result = {8'h00, r8};
        res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      sm83alu_pkg::OP_XOR: begin
        r8 = a8 ^ b8;
        res.result = {8'h00, r8};
        res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      sm83alu_pkg::OP_INC: begin
        r8 = a8 + 8'h01;
        res.result = {8'h00, r8};
        res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: (a8[3:0] == 4'hF), c: req.flags.c};
      end
      sm83alu_pkg::OP_DEC: begin
        r8 = a8 - 8'h01;
        res.result = {8'h00, r8};
        res.flags  = '{z: (r8 == 8'h00), n: 1'b1, h: (a8[3:0] == 4'h0), c: req.flags.c};
      end
      sm83alu_pkg::OP_SWAP: begin
        r8 = {a8[3:0], a8[7:4]};
        res.result = {8'h00, r8};
        res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      sm83alu_pkg::OP_BIT: begin
        res.flags = '{z: ((a8 & bmask) == 8'h00), n: 1'b0, h: 1'b1, c: req.flags.c};
      end
      sm83alu_pkg::OP_RES: begin
        r8 = a8 & ~bmask;
        res.result = {8'h00, r8};
      end
      sm83alu_pkg::OP_SET: begin
        r8 = a8 | bmask;
        res.result = {8'h00, r8};
      end
      sm83alu_pkg::OP_RLC: begin
        r8 = {a8[6:0], a8[7]};
        res.result  = {8'h00, r8};
        res.flags.c = a8[7];
      end
      sm83alu_pkg::OP_RRC: begin
        r8 = {a8[0], a8[7:1]};
        res.result  = {8'h00, r8};
        res.flags.c = a8[0];
      end
      sm83alu_pkg::OP_RL: begin
        r8 = {a8[6:0], req.flags.c};
        res.result  = {8'h00, r8};
        res.flags.c = a8[7];
      end
      sm83alu_pkg::OP_RR: begin
        r8 = {req.flags.c, a8[7:1]};
        res.result  = {8'h00, r8};
        res.flags.c = a8[0];
      end
      sm83alu_pkg::OP_SLA: begin
        r8 = {a8[6:0], 1'b0};
        res.result = {8'h00, r8};
        res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a8[7]};
      end
      sm83alu_pkg::OP_SRA: begin
        r8 = {a8[7], a8[7:1]};
        res.result = {8'h00, r8};
        res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a8[0]};
      end
      sm83alu_pkg::OP_SRL: begin
        r8 = {1'b0, a8[7:1]};
        res.result = {8'h00, r8};
        res.flags  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a8[0]};
      end
      sm83alu_pkg::OP_DAA: begin
        r8 = daa_r;
        res.result = {8'h00, r8};
        res.flags  = '{z: (r8 == 8'h00), n: req.flags.n, h: 1'b0,
                       c: req.flags.c | (~req.flags.n & daa_t2[8])};
      end
      sm83alu_pkg::OP_ADD16: begin
        res.result = sum17[15:0];
        res.flags  = '{z: req.flags.z, n: 1'b0, h: sum13[12], c: sum17[16]};
      end
      sm83alu_pkg::OP_INC16: begin
        res.result = req.a + 16'h0001;
      end
      sm83alu_pkg::OP_DEC16: begin
        res.result = req.a - 16'h0001;
      end
      sm83alu_pkg::OP_SPOFS: begin
        // flags from the unsigned add of the low bytes
        res.result = sp_sum;
        res.flags  = '{z: 1'b0, n: 1'b0, h: hsum[4], c: sum9[8]};
      end
      default: begin
        res.result = req.a;
        res.flags  = req.flags;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/sm83_alu_with_flags.sv =====
// top level of the sm83 alu with flags: input register, datapath, result register
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  in_     | request   | in_valid / in_ready   | req_type, operand_a/b, bit_index, 4 flags
//  out_    | result    | out_valid / out_ready | result, zero/neg/half/carry out
//
// a request accepted on in_ is registered in the input stage, then in the result stage, and
// is offered on out_ from there; one request per cycle is taken and one result per cycle
// is delivered for as long as out_ready stays high
// the only logic between the two registers is the alu datapath (8/16-bit adders, muxes)
// rst_n is synchronous and active low; it empties both stages, payload is not cleared
// when out_ready is low the result stage holds and the input stage still fills once,
// so in_ready drops only with both stages full
`default_nettype none

module sm83_alu_with_flags (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_req_type,
  input  wire logic [15:0] in_operand_a,
  input  wire logic [15:0] in_operand_b,
  input  wire logic [2:0]  in_bit_index,
  input  wire logic        in_zero_in,
  input  wire logic        in_neg_in,
  input  wire logic        in_half_in,
  input  wire logic        in_carry_in,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_result,
  output logic             out_zero_out,
  output logic             out_neg_out,
  output logic             out_half_out,
  output logic             out_carry_out
);

  // input stage
  sm83alu_pkg::alu_req_t req_nxt;
  sm83alu_pkg::alu_req_t req_r;
  logic                  req_vld_r;
  logic                  req_vld_nxt;
  // result stage
  sm83alu_pkg::alu_res_t res_nxt;
  sm83alu_pkg::alu_res_t res_r;
  logic                  res_vld_r;
  logic                  res_vld_nxt;

  logic                  in_take;
  logic                  req_move;

  // pack the request ports; unused opcodes keep their code and fall to the default arm
  assign req_nxt = '{op:        sm83alu_pkg::alu_op_t'(in_req_type),
                     a:         in_operand_a,
                     b:         in_operand_b,
                     bit_index: in_bit_index,
                     flags:     '{z: in_zero_in, n: in_neg_in, h: in_half_in, c: in_carry_in}};

  // the input stage moves on whenever the result stage is empty or being drained
  assign req_move = req_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !req_vld_r || !res_vld_r || out_ready;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    req_vld_nxt = in_take || (req_vld_r && !req_move);
    res_vld_nxt = req_move || (res_vld_r && !out_ready);
  end

  // all the arithmetic sits between req_r and res_r
  sm83alu_core u_core (
    .req (req_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= req_nxt;
    end
    if (req_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = res_vld_r;
  assign out_result    = res_r.result;
  assign out_zero_out  = res_r.flags.z;
  assign out_neg_out   = res_r.flags.n;
  assign out_half_out  = res_r.flags.h;
  assign out_carry_out = res_r.flags.c;

endmodule

`default_nettype wire

// ===== design/sm83alu_chk.sv =====
// port-level checker for the sm83 alu with flags and its bind
`default_nettype none

module sm83alu_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_result,
  input wire logic        out_zero_out,
  input wire logic        out_neg_out,
  input wire logic        out_half_out,
  input wire logic        out_carry_out
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result) && $stable(out_zero_out)
      && $stable(out_neg_out) && $stable(out_half_out) && $stable(out_carry_out))
    else $error("result payload changed while stalled");

  // back-pressure only with both stages full and the output stalled
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request refused with room in the pipeline");

  // a result appearing from empty was accepted and passed through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching request");

endmodule

bind sm83_alu_with_flags sm83alu_chk u_sm83alu_chk (.*);

`default_nettype wire
